// ===== design/twrtc_pkg.sv =====
// Shared types, codes and helpers for the three-wire clock-chip bus master.
package twrtc_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int IDX_W = $clog2(BITS_PER_BYTE);
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(BITS_PER_BYTE - 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_WDATA = 2'd2;
  localparam logic [1:0] PH_RDATA = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] command_byte;
    logic [7:0] write_value;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       start_ignored;
    logic [7:0] read_decoded;
    logic [7:0] read_raw;
    logic       done_res;
    logic       busy_res;
    logic       line_drive;
    logic       line_out;
    logic       enable_level;
    logic       clock_level;
  } res_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] raw);
    logic [7:0] hi;
    hi = {4'b0000, raw[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0000, raw[3:0]};
  endfunction

endpackage

// ===== design/three_wire_rtc_bus_master.sv =====
// Top level of the three-wire clock-chip bus master with its stream registers.
//
// Input items arrive on the s_axis channel: tuser carries the request kind
// (tick, start read, start write, no operation) and tdata carries the command
// byte, the write byte and the sampled data line. Each tick item advances the
// bus by one half bit time; a start loads a transaction and raises enable.
// Every input item yields exactly one result item on the m_axis channel with
// the line levels after that step, the busy and done flags, the read byte and
// its value decoded from BCD, and a flag for a start that arrived while busy.
// An accepted item is held in the input register, stepped through the bus
// state combinationally and, once the output register is free, loaded into
// the output register, from which its result is offered on m_axis.
// One item is accepted every cycle while results drain.
// When the receiver stalls, the output register holds its result and the input
// register holds the next item; s_axis_tready falls only when both are full.
// Reset empties both registers and returns the bus to idle with all lines low.
module three_wire_rtc_bus_master
  import twrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] command_byte, [15:8] write_value, [16] line_in, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] clock_level, [1] enable_level, [2] line_out, [3] line_drive,
  // [4] busy_res, [5] done_res, [13:6] read_raw, [21:14] read_decoded,
  // [22] start_ignored, [23] zero
  output logic [23:0] m_axis_tdata
);

  logic  in_valid;
  item_t in_item;
  logic  out_valid;
  res_t  out_res;
  res_t  step_res;
  logic  advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.req_type     <= s_axis_tuser;
      in_item.command_byte <= s_axis_tdata[7:0];
      in_item.write_value  <= s_axis_tdata[15:8];
      in_item.line_in      <= s_axis_tdata[16];
    end
  end

  twrtc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

endmodule

// ===== design/twrtc_step.sv =====
// Bus state registers and the per-item step that produces one result.
module twrtc_step
  import twrtc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  output res_t  res
);

  logic [1:0]       phase, phase_next;
  logic [IDX_W-1:0] bit_index, bit_index_next;
  logic             clock_high_half, clock_high_half_next;
  logic [7:0]       out_shift, out_shift_next;
  logic [7:0]       in_shift, in_shift_next;
  logic             is_read, is_read_next;
  logic [7:0]       data_hold, data_hold_next;

  always_comb begin
    logic last;
    logic drive;
    phase_next           = phase;
    bit_index_next       = bit_index;
    clock_high_half_next = clock_high_half;
    out_shift_next       = out_shift;
    in_shift_next        = in_shift;
    is_read_next         = is_read;
    data_hold_next       = data_hold;
    res                  = '0;
    last                 = (bit_index == LAST_BIT);
    if (item.req_type == REQ_READ || item.req_type == REQ_WRITE) begin
      if (phase != PH_IDLE) begin
        res.start_ignored = 1'b1;
      end else begin
        out_shift_next       = item.command_byte;
        data_hold_next       = item.write_value;
        is_read_next         = (item.req_type == REQ_READ);
        in_shift_next        = '0;
        bit_index_next       = '0;
        clock_high_half_next = 1'b0;
        phase_next           = PH_CMD;
      end
    end else if (item.req_type == REQ_TICK && phase != PH_IDLE) begin
      if (!clock_high_half) begin
        if (phase == PH_RDATA) begin
          in_shift_next = {item.line_in, in_shift[7:1]};
        end
        clock_high_half_next = 1'b1;
      end else begin
        clock_high_half_next = 1'b0;
        bit_index_next = last ? '0 : bit_index + 1'b1;
        if (phase == PH_RDATA) begin
          if (last) begin
            res.done_res     = 1'b1;
            res.read_raw     = in_shift;
            res.read_decoded = bcd_value(in_shift);
            phase_next       = PH_IDLE;
          end
        end else begin
          out_shift_next = {1'b0, out_shift[7:1]};
          if (last) begin
            if (phase == PH_CMD) begin
              if (is_read) begin
                phase_next    = PH_RDATA;
                in_shift_next = '0;
              end else begin
                phase_next     = PH_WDATA;
                out_shift_next = data_hold;
              end
            end else begin
              res.done_res = 1'b1;
              phase_next   = PH_IDLE;
            end
          end
        end
      end
    end
    drive            = (phase_next == PH_CMD || phase_next == PH_WDATA);
    res.clock_level  = (phase_next != PH_IDLE) && clock_high_half_next;
    res.enable_level = (phase_next != PH_IDLE);
    res.busy_res     = (phase_next != PH_IDLE);
    res.line_drive   = drive;
    res.line_out     = drive && out_shift_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_index       <= '0;
      clock_high_half <= 1'b0;
      out_shift       <= '0;
      in_shift        <= '0;
      is_read         <= 1'b0;
      data_hold       <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      clock_high_half <= clock_high_half_next;
      out_shift       <= out_shift_next;
      in_shift        <= in_shift_next;
      is_read         <= is_read_next;
      data_hold       <= data_hold_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (bit_index == '0 && !clock_high_half))
    else $error("idle phase with bit position or clock half left over");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && res.done_res) |=> (phase == PH_IDLE))
    else $error("transaction end did not return to idle");

  a_ignored_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && res.start_ignored) |=> ($stable(phase) && $stable(bit_index)
                                     && $stable(out_shift)))
    else $error("dropped start disturbed the transaction");

  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    res.line_drive |-> (res.busy_res && res.enable_level && !res.done_res))
    else $error("data line driven outside a transaction");

endmodule

// ===== dv/tb.sv =====
// Self-checking stream testbench for the three-wire clock-chip bus master.
module tb
  import twrtc_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int TARGET_BUS_ITEMS = 1050;
  localparam int TICKS_PER_TXN = 4 * BITS_PER_BYTE;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;
  logic [1:0]  s_user = REQ_NOP;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;

  logic [1:0] bus_phase = PH_IDLE;
  logic [2:0] bit_count = '0;
  logic       sclk_high = 1'b0;
  logic [7:0] tx_shift = '0;
  logic [7:0] rx_shift = '0;
  logic       txn_is_read = 1'b0;
  logic [7:0] tx_data_byte = '0;

  res_t line_states_due[$];

  bit allow_gaps = 1'b1;
  int fault_count = 0;
  int results_seen = 0;
  int bus_items = 0;
  int reads_run = 0;
  int writes_run = 0;
  int starts_dropped = 0;
  int cycle_count = 0;
  int stall_left = 0;

  three_wire_rtc_bus_master dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the bus by one request and returns the line levels after it.
  function automatic res_t next_bus_levels(input logic [1:0] req, input logic [7:0] cmd,
                                           input logic [7:0] wval, input logic lin);
    res_t r;
    logic byte_done;
    logic drive;
    r = '0;
    if (req == REQ_READ || req == REQ_WRITE) begin
      if (bus_phase != PH_IDLE) begin
        r.start_ignored = 1'b1;
      end else begin
        tx_shift = cmd;
        tx_data_byte = wval;
        txn_is_read = (req == REQ_READ);
        rx_shift = '0;
        bit_count = '0;
        sclk_high = 1'b0;
        bus_phase = PH_CMD;
      end
    end else if (req == REQ_TICK && bus_phase != PH_IDLE) begin
      if (!sclk_high) begin
        if (bus_phase == PH_RDATA) rx_shift = {lin, rx_shift[7:1]};
        sclk_high = 1'b1;
      end else begin
        if (bus_phase != PH_RDATA) tx_shift = tx_shift >> 1;
        byte_done = (bit_count == 3'(BITS_PER_BYTE - 1));
        bit_count = byte_done ? 3'd0 : bit_count + 3'd1;
        sclk_high = 1'b0;
        if (byte_done) begin
          if (bus_phase == PH_CMD) begin
            if (txn_is_read) begin
              bus_phase = PH_RDATA;
              rx_shift = '0;
            end else begin
              bus_phase = PH_WDATA;
              tx_shift = tx_data_byte;
            end
          end else begin
            r.done_res = 1'b1;
            if (bus_phase == PH_RDATA) begin
              r.read_raw = rx_shift;
              r.read_decoded = 8'(rx_shift[7:4] * 10 + rx_shift[3:0]);
            end
            bus_phase = PH_IDLE;
          end
        end
      end
    end
    drive = (bus_phase == PH_CMD || bus_phase == PH_WDATA);
    r.clock_level = (bus_phase != PH_IDLE) && sclk_high;
    r.enable_level = (bus_phase != PH_IDLE);
    r.busy_res = (bus_phase != PH_IDLE);
    r.line_drive = drive;
    r.line_out = drive && tx_shift[0];
    return r;
  endfunction

  function automatic string levels_text(input res_t r);
    return $sformatf("clk=%b en=%b out=%b drv=%b busy=%b done=%b raw=%h dec=%0d ign=%b",
                     r.clock_level, r.enable_level, r.line_out, r.line_drive, r.busy_res,
                     r.done_res, r.read_raw, r.read_decoded, r.start_ignored);
  endfunction

  task automatic push_request(input logic [1:0] req, input logic [7:0] cmd,
                              input logic [7:0] wval, input logic lin);
    res_t want;
    if (allow_gaps && $urandom_range(0, 9) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= req;
    s_data <= {7'b0, lin, wval, cmd};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    want = next_bus_levels(req, cmd, wval, lin);
    if (want.start_ignored) starts_dropped++;
    bus_items++;
    line_states_due.push_back(want);
  endtask

  task automatic push_noise(input bit busy);
    int pick;
    pick = busy ? $urandom_range(0, 3) : $urandom_range(0, 1);
    case (pick)
      0: begin
        push_request(REQ_NOP, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end
      1: begin
        push_request(REQ_TICK, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end
      2: begin
        push_request(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end
      default: begin
        push_request(REQ_WRITE, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  task automatic begin_txn(input logic rd, input logic [7:0] cmd, input logic [7:0] wval);
    push_request(rd ? REQ_READ : REQ_WRITE, cmd, wval, 1'($urandom_range(0, 1)));
    if (rd) reads_run++;
    else writes_run++;
  endtask

  // Ticks a transaction to its end, noise ticks aside; rx_byte is on rising ticks.
  task automatic clock_out_txn(input logic [7:0] rx_byte, input int noise_pct);
    logic lin;
    for (int t = 0; t < TICKS_PER_TXN; t++) begin
      if ($urandom_range(0, 99) < noise_pct) push_noise(1'b1);
      if (t >= TICKS_PER_TXN / 2 && t % 2 == 0) begin
        lin = rx_byte[3'((t - TICKS_PER_TXN / 2) / 2)];
      end else begin
        lin = 1'($urandom_range(0, 1));
      end
      push_request(REQ_TICK, 8'($urandom), 8'($urandom), lin);
    end
  endtask

  task automatic test_idle_requests();
    push_request(REQ_TICK, 8'hFF, 8'hFF, 1'b1);
    push_request(REQ_NOP, 8'hFF, 8'hFF, 1'b1);
    push_request(REQ_NOP, 8'h00, 8'h00, 1'b0);
    push_request(REQ_TICK, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_write_extremes();
    begin_txn(1'b0, 8'h00, 8'hFF);
    clock_out_txn(8'h00, 0);
    begin_txn(1'b0, 8'hFF, 8'h00);
    clock_out_txn(8'h00, 0);
  endtask

  task automatic test_busy_starts();
    begin_txn(1'b1, 8'h85, 8'h00);
    push_request(REQ_WRITE, 8'h80, 8'hFF, 1'b1);
    push_request(REQ_READ, 8'hFF, 8'hFF, 1'b1);
    push_request(REQ_NOP, 8'hFF, 8'hFF, 1'b1);
    clock_out_txn(8'hFF, 0);
  endtask

  task automatic test_read_values();
    begin_txn(1'b1, 8'h81, 8'hFF);
    clock_out_txn(8'h59, 0);
    begin_txn(1'b1, 8'h01, 8'h00);
    clock_out_txn(8'h00, 0);
  endtask

  task automatic test_random_traffic();
    while (bus_items < TARGET_BUS_ITEMS) begin
      if (bus_items > TARGET_BUS_ITEMS - 150) allow_gaps = 1'b0;
      repeat ($urandom_range(0, 3)) push_noise(1'b0);
      begin_txn(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
      clock_out_txn(8'($urandom), ($urandom_range(0, 3) == 0) ? 30 : 3);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    logic rdy;
    if (!rst && m_valid && m_ready) begin
      got = res_t'(m_data[22:0]);
      results_seen++;
      if (line_states_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("tb: unexpected result %s", levels_text(got));
      end else begin
        want = line_states_due.pop_front();
        if (got.clock_level !== want.clock_level || got.enable_level !== want.enable_level ||
            got.line_out !== want.line_out || got.line_drive !== want.line_drive ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.read_raw !== want.read_raw || got.read_decoded !== want.read_decoded ||
            got.start_ignored !== want.start_ignored || m_data[23] !== 1'b0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("tb: mismatch at result %0d", results_seen);
            $display("  expected %s", levels_text(want));
            $display("  actual   %s spare=%b", levels_text(got), m_data[23]);
          end
        end
      end
    end
    if (!allow_gaps) begin
      stall_left = 0;
      rdy = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 14);
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    m_ready <= rdy;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timed out with %0d results pending", line_states_due.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_requests();
    test_write_extremes();
    test_busy_starts();
    test_read_values();
    test_random_traffic();
    s_valid <= 1'b0;
    while (line_states_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d reads and %0d writes, %0d dropped starts, %0d results checked",
             reads_run, writes_run, starts_dropped, results_seen);
    $display("tb: %0d mismatches in %0d cycles", fault_count, cycle_count);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
